>>> rtl/lru_pkg.sv
// shared constants and helpers for the lru list with eviction report
package lru_pkg;

    localparam int CAP_BITS       = 5;
    localparam int ADDR_BITS      = 3;
    localparam int DATA_BITS      = 32;
    localparam int DEF_ENTRIES    = 16;
    localparam int DEF_KEY_BITS   = 20;
    localparam int DEF_INDEX_BITS = 20;
    localparam int CAP_RESET      = 16;

    typedef enum logic [0:0] {
        REG_CAPACITY = 1'b0,
        REG_UNUSED   = 1'b1
    } t_reg_idx;

    // forward chain between neighboring cells
    typedef struct packed {
        logic found;
    } t_link;

    // clamp a written capacity into 1..entries
    function automatic logic [CAP_BITS-1:0] clamp_cap(input logic [CAP_BITS-1:0] v,
                                                     input int entries);
        logic [CAP_BITS-1:0] r;
        r = v;
        if (v == '0) begin
            r = CAP_BITS'(1);
        end else if (int'(v) > entries) begin
            r = CAP_BITS'(entries);
        end
        return r;
    endfunction

endpackage

>>> rtl/lru_cell.sv
// one list entry: key register, compare and move-to-front shift
module lru_cell #(
    parameter int KEY_BITS = 20,
    parameter int IDX      = 0
) (
    input  logic                         i_clk,
    input  logic                         i_load,
    input  logic [lru_pkg::CAP_BITS-1:0] i_load_cap,
    input  logic [lru_pkg::CAP_BITS-1:0] i_cap,
    input  logic                         i_update,
    input  logic [KEY_BITS-1:0]          i_key,
    input  logic [KEY_BITS-1:0]          i_prev_key,
    input  lru_pkg::t_link               i_link,
    output lru_pkg::t_link               o_link,
    input  logic [KEY_BITS-1:0]          i_evict,
    output logic [KEY_BITS-1:0]          o_evict,
    output logic [KEY_BITS-1:0]          o_key
);
    import lru_pkg::*;

    logic [KEY_BITS-1:0] r_key;
    logic                w_active;
    logic                w_last;
    logic                w_match;
    logic                w_take;

    assign w_active = IDX < int'(i_cap);
    assign w_last   = IDX == int'(i_cap) - 1;
    assign w_match  = w_active && (r_key == i_key);
    // cells up to the hit position (or the whole list on a miss) take their neighbor's key
    assign w_take   = w_active && !i_link.found;

    assign o_link.found = i_link.found | w_match;
    assign o_evict      = w_last ? r_key : i_evict;
    assign o_key        = r_key;

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_key <= (IDX < int'(i_load_cap)) ? KEY_BITS'(IDX + 1) : '0;
        end else if (i_update && w_take) begin
            r_key <= i_prev_key;
        end
    end

endmodule

>>> rtl/lru_list_with_eviction_report.sv
// top level: recency list of key cells with apb capacity register
// Usage
//   input channel: i_in_valid / o_in_stall carry i_access_key; a request is
//   taken at a rising edge with i_in_valid high and o_in_stall low.
//   output channel: o_out_valid / i_out_stall carry o_hit, o_evicted_key and
//   o_access_index, one result per request, in request order.
//   timing: the result is registered and shows in the cycle after the request.
//   throughput: one request per cycle unless stalled; all cells compare the
//   key against their entry in the same cycle and the hit flag ripples down
//   the row of cells, which sets the cycle time for a large ENTRIES.
//   stall: while a result waits with i_out_stall high, o_in_stall is high and
//   the list holds; the result stays stable until taken.
//   reset: capacity returns to 16 (clamped to ENTRIES), the list reloads keys
//   1..capacity with key 1 most recent and the access count clears.
//   apb write of capacity (address 0) reloads the list the same way and
//   restarts the count; write it only while the block is idle.
module lru_list_with_eviction_report #(
    parameter int ENTRIES    = lru_pkg::DEF_ENTRIES,
    parameter int KEY_BITS   = lru_pkg::DEF_KEY_BITS,
    parameter int INDEX_BITS = lru_pkg::DEF_INDEX_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [lru_pkg::ADDR_BITS-1:0] paddr,
    input  logic [lru_pkg::DATA_BITS-1:0] pwdata,
    output logic [lru_pkg::DATA_BITS-1:0] prdata,
    output logic                          pready,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [KEY_BITS-1:0]           i_access_key,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic                          o_hit,
    output logic [KEY_BITS-1:0]           o_evicted_key,
    output logic [INDEX_BITS-1:0]         o_access_index
);
    import lru_pkg::*;

    localparam logic [INDEX_BITS-1:0] INDEX_MAX = '1;

    logic [CAP_BITS-1:0]   r_capacity;
    logic [INDEX_BITS-1:0] r_count;
    logic [INDEX_BITS-1:0] n_count;
    logic                  r_out_valid;
    logic                  r_hit;
    logic [KEY_BITS-1:0]   r_evicted;
    logic [INDEX_BITS-1:0] r_index;

    logic                  w_cfg_wr;
    logic                  w_load;
    logic [CAP_BITS-1:0]   w_load_cap;
    logic                  w_accept;
    t_reg_idx              w_reg;

    t_link                 w_link  [0:ENTRIES];
    logic [KEY_BITS-1:0]   w_evict [0:ENTRIES];
    logic [KEY_BITS-1:0]   w_key   [0:ENTRIES];

    assign pready   = 1'b1;
    assign w_reg    = t_reg_idx'(paddr[ADDR_BITS-1]);
    assign w_cfg_wr = psel && penable && pwrite && pready && (w_reg == REG_CAPACITY);
    assign prdata   = (w_reg == REG_CAPACITY) ? DATA_BITS'(r_capacity) : '0;

    assign w_load     = !i_rst_n || w_cfg_wr;
    assign w_load_cap = !i_rst_n ? clamp_cap(CAP_BITS'(CAP_RESET), ENTRIES)
                                 : clamp_cap(pwdata[CAP_BITS-1:0], ENTRIES);

    assign o_in_stall = r_out_valid && i_out_stall;
    assign w_accept   = i_in_valid && !o_in_stall;

    assign w_link[0].found = 1'b0;
    assign w_evict[0]      = '0;
    assign w_key[0]        = i_access_key;

    for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
        lru_cell #(
            .KEY_BITS (KEY_BITS),
            .IDX      (g)
        ) u_cell (
            .i_clk      (i_clk),
            .i_load     (w_load),
            .i_load_cap (w_load_cap),
            .i_cap      (r_capacity),
            .i_update   (w_accept),
            .i_key      (i_access_key),
            .i_prev_key (w_key[g]),
            .i_link     (w_link[g]),
            .o_link     (w_link[g+1]),
            .i_evict    (w_evict[g]),
            .o_evict    (w_evict[g+1]),
            .o_key      (w_key[g+1])
        );
    end

    assign n_count = (r_count < INDEX_MAX) ? r_count + INDEX_BITS'(1) : r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity  <= w_load_cap;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_cfg_wr) begin
                r_capacity <= w_load_cap;
                r_count    <= '0;
            end else if (w_accept) begin
                r_count <= n_count;
            end
            if (w_accept) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_hit     <= w_link[ENTRIES].found;
            r_evicted <= w_link[ENTRIES].found ? '0 : w_evict[ENTRIES];
            r_index   <= n_count;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_hit          = r_hit;
    assign o_evicted_key  = r_evicted;
    assign o_access_index = r_index;

endmodule
